### design/spectrum_bar_peak_falloff_unit_defines.svh
// assertion macros for the spectrum bar peak falloff unit
// used by the rtl files that carry checks, no other dependencies
`ifndef SPECTRUM_BAR_PEAK_FALLOFF_UNIT_DEFINES_SVH
`define SPECTRUM_BAR_PEAK_FALLOFF_UNIT_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SBPF_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpf same-cycle check failed");
// antecedent implies consequent in the next cycle
`define SBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpf next-cycle check failed");
`else
`define SBPF_ASSERT_HOLD(label, clk, rst_n, ante, cons)
`define SBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/sbpf_pkg.sv
// package for the spectrum bar peak falloff unit: sizes, word types, band edge rom
// no dependencies
package sbpf_pkg;

  localparam int NUM_BANDS     = 40;
  localparam int FRAME_BINS    = 512;
  localparam int ROM_BANDS     = 40;
  localparam int ACTIVE_BANDS  = (NUM_BANDS < ROM_BANDS) ? NUM_BANDS : ROM_BANDS;

  localparam int MAG_W         = 16;
  localparam int BAR_W         = 9;
  localparam int BAND_W        = 6;
  localparam int EDGE_W        = 9;
  localparam int PEAK_SHIFT    = 7;
  localparam int BIN_W         = $clog2(FRAME_BINS);
  localparam int CMP_W         = ((BIN_W > EDGE_W) ? BIN_W : EDGE_W) + 1;
  localparam int BAND_AW       = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam logic [BAR_W-1:0] FALLOFF_RESET = 9'd2;
  localparam logic CFG_IDX_FALLOFF = 1'b0;

  typedef struct packed {
    logic [MAG_W-1:0] bin_magnitude;
    logic             frame_last;
  } in_word_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_number;
    logic [BAR_W-1:0]  bar_height;
  } out_word_t;

  typedef struct packed {
    logic               en;
    logic [BAND_AW-1:0] addr;
    logic [BAR_W-1:0]   data;
  } bar_wr_t;

  typedef struct packed {
    logic               en;
    logic [BAND_AW-1:0] addr;
  } bar_rd_t;

  function automatic logic [EDGE_W-1:0] band_edge(input logic [BAND_W-1:0] idx);
    logic [EDGE_W-1:0] e;
    case (idx)
      6'd0:  e = 9'd0;
      6'd1:  e = 9'd1;
      6'd2:  e = 9'd2;
      6'd3:  e = 9'd3;
      6'd4:  e = 9'd4;
      6'd5:  e = 9'd5;
      6'd6:  e = 9'd6;
      6'd7:  e = 9'd7;
      6'd8:  e = 9'd8;
      6'd9:  e = 9'd9;
      6'd10: e = 9'd11;
      6'd11: e = 9'd12;
      6'd12: e = 9'd13;
      6'd13: e = 9'd14;
      6'd14: e = 9'd15;
      6'd15: e = 9'd16;
      6'd16: e = 9'd17;
      6'd17: e = 9'd18;
      6'd18: e = 9'd19;
      6'd19: e = 9'd20;
      6'd20: e = 9'd24;
      6'd21: e = 9'd27;
      6'd22: e = 9'd29;
      6'd23: e = 9'd31;
      6'd24: e = 9'd35;
      6'd25: e = 9'd40;
      6'd26: e = 9'd50;
      6'd27: e = 9'd60;
      6'd28: e = 9'd70;
      6'd29: e = 9'd80;
      6'd30: e = 9'd90;
      6'd31: e = 9'd100;
      6'd32: e = 9'd120;
      6'd33: e = 9'd140;
      6'd34: e = 9'd160;
      6'd35: e = 9'd180;
      6'd36: e = 9'd240;
      6'd37: e = 9'd300;
      6'd38: e = 9'd350;
      6'd39: e = 9'd450;
      6'd40: e = 9'd511;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### design/sbpf_cfg.sv
// apb-style register file for the falloff step
// depends on sbpf_pkg
module sbpf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbpf_pkg::CFG_AW-1:0] paddr,
  input  logic [sbpf_pkg::CFG_DW-1:0] pwdata,
  output logic [sbpf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [sbpf_pkg::BAR_W-1:0]  falloff_step
);

  logic [sbpf_pkg::BAR_W-1:0] falloff_r;
  logic                       reg_sel;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == sbpf_pkg::CFG_IDX_FALLOFF);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      falloff_r <= sbpf_pkg::FALLOFF_RESET;
    end else if (wr_en) begin
      falloff_r <= pwdata[sbpf_pkg::BAR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(sbpf_pkg::CFG_DW-sbpf_pkg::BAR_W){1'b0}}, falloff_r};
    end
  end

  assign falloff_step = falloff_r;

endmodule

### design/sbpf_bar_mem.sv
// bar height store: one write port, one registered read port, per-entry valid bits
// depends on sbpf_pkg
module sbpf_bar_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sbpf_pkg::bar_wr_t          wr,
  input  sbpf_pkg::bar_rd_t          rd,
  output logic [sbpf_pkg::BAR_W-1:0] rd_bar
);

  logic [sbpf_pkg::BAR_W-1:0]     mem [sbpf_pkg::NUM_BANDS];
  logic [sbpf_pkg::NUM_BANDS-1:0] vld_r;
  logic [sbpf_pkg::BAR_W-1:0]     rd_data_r;
  logic                           rd_vld_r;
  logic                           rd_hit;

  assign rd_hit = wr.en && (wr.addr == rd.addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // write-first bypass keeps the read word current
  always_ff @(posedge clk) begin
    if (rd_hit) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd.en && (rd_hit || vld_r[rd.addr]);
    end
  end

  assign rd_bar = rd_vld_r ? rd_data_r : '0;

endmodule

### design/sbpf_band_proc.sv
// band tracking: bin and band counters, running peak, bar rise and falloff
// depends on sbpf_pkg and spectrum_bar_peak_falloff_unit_defines.svh
`include "spectrum_bar_peak_falloff_unit_defines.svh"

module sbpf_band_proc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       proc_en,
  input  sbpf_pkg::in_word_t         in_word,
  input  logic [sbpf_pkg::BAR_W-1:0] falloff_step,
  input  logic [sbpf_pkg::BAR_W-1:0] bar_cur,
  output logic                       res_valid,
  output sbpf_pkg::out_word_t        res_word,
  output sbpf_pkg::bar_wr_t          bar_wr,
  output sbpf_pkg::bar_rd_t          bar_rd
);

  logic [sbpf_pkg::BIN_W-1:0]  bin_cnt_r,  bin_cnt_nxt;
  logic [sbpf_pkg::BAND_W-1:0] band_cnt_r, band_cnt_nxt;
  logic [sbpf_pkg::MAG_W-1:0]  peak_r,     peak_nxt;

  logic                        band_active;
  logic                        band_done;
  logic                        frame_end;
  logic [sbpf_pkg::MAG_W-1:0]  peak_max;
  logic [sbpf_pkg::EDGE_W-1:0] edge_hi;
  logic [sbpf_pkg::CMP_W-1:0]  bin_plus;
  logic [sbpf_pkg::BAR_W-1:0]  peak_y;
  logic [sbpf_pkg::BAR_W-1:0]  bar_new;

  always_comb begin
    band_active = band_cnt_r < sbpf_pkg::BAND_W'(sbpf_pkg::ACTIVE_BANDS);
    peak_max    = (in_word.bin_magnitude > peak_r) ? in_word.bin_magnitude : peak_r;
    edge_hi     = sbpf_pkg::band_edge(band_cnt_r + 6'd1);
    bin_plus    = sbpf_pkg::CMP_W'(bin_cnt_r) + sbpf_pkg::CMP_W'(1);
    band_done   = band_active && (bin_plus == sbpf_pkg::CMP_W'(edge_hi));
    frame_end   = in_word.frame_last ||
                  (bin_cnt_r == sbpf_pkg::BIN_W'(sbpf_pkg::FRAME_BINS - 1));
    peak_y      = peak_max[sbpf_pkg::PEAK_SHIFT +: sbpf_pkg::BAR_W];

    if (peak_y > bar_cur) begin
      bar_new = peak_y;
    end else if (bar_cur > falloff_step) begin
      bar_new = bar_cur - falloff_step;
    end else begin
      bar_new = '0;
    end

    bin_cnt_nxt  = bin_cnt_r;
    band_cnt_nxt = band_cnt_r;
    peak_nxt     = peak_r;
    if (proc_en) begin
      if (band_done) begin
        band_cnt_nxt = band_cnt_r + 6'd1;
        peak_nxt     = '0;
      end else if (band_active) begin
        peak_nxt     = peak_max;
      end
      if (frame_end) begin
        bin_cnt_nxt  = '0;
        band_cnt_nxt = '0;
        peak_nxt     = '0;
      end else begin
        bin_cnt_nxt  = bin_cnt_r + 1'b1;
      end
    end

    res_valid            = proc_en && band_done;
    res_word.band_number = band_cnt_r;
    res_word.bar_height  = bar_new;

    bar_wr.en   = proc_en && band_done;
    bar_wr.addr = band_cnt_r[sbpf_pkg::BAND_AW-1:0];
    bar_wr.data = bar_new;

    // prefetch the bar of the band that the next bin belongs to
    bar_rd.en   = {1'b0, band_cnt_nxt} < (sbpf_pkg::BAND_W + 1)'(sbpf_pkg::NUM_BANDS);
    bar_rd.addr = band_cnt_nxt[sbpf_pkg::BAND_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r  <= '0;
      band_cnt_r <= '0;
      peak_r     <= '0;
    end else begin
      bin_cnt_r  <= bin_cnt_nxt;
      band_cnt_r <= band_cnt_nxt;
      peak_r     <= peak_nxt;
    end
  end

  `SBPF_ASSERT_NEXT(a_frame_restart, clk, rst_n, proc_en && frame_end, (bin_cnt_r == '0) && (band_cnt_r == '0) && (peak_r == '0))
  `SBPF_ASSERT_NEXT(a_band_advance, clk, rst_n, proc_en && band_done && !frame_end, band_cnt_r == $past(band_cnt_r) + 6'd1)
  `SBPF_ASSERT_NEXT(a_idle_hold, clk, rst_n, !proc_en, $stable(bin_cnt_r) && $stable(band_cnt_r))
  `SBPF_ASSERT_HOLD(a_result_band, clk, rst_n, res_valid, band_cnt_r < sbpf_pkg::BAND_W'(sbpf_pkg::ACTIVE_BANDS))

endmodule

### design/spectrum_bar_peak_falloff_unit.sv
// top level of the spectrum bar peak falloff unit: input and result registers
// depends on sbpf_pkg, sbpf_cfg, sbpf_bar_mem, sbpf_band_proc
//
// in_valid/in_stall carries one fft bin word per accepted cycle, in bin order;
// frame_last on a word ends the frame and restarts bin and band counting.
// out_valid/out_stall carries one word (band number, new bar height) each time
// the last bin of a band is handled; other bins give no word.
// an accepted word is held in the input register and handled from there once
// out_stall holds no pending result; its result is then registered in the
// output register that drives out_valid and out_word.
// throughput: one bin per cycle unless out_stall holds a pending result; the
// band state and prefetched bar memory word update each cycle a bin is handled.
// while out_stall holds a pending result, the bin in the input register waits
// and in_stall rises; one more bin is still taken when the input register is
// empty.
// reset (rst_n low, synchronous): all bars read as zero, counters and the band
// peak clear, falloff_step returns to 2. the user must write configuration over
// the apb port only while no bins are in flight; the block does not enforce it.
module spectrum_bar_peak_falloff_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sbpf_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbpf_pkg::out_word_t         out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbpf_pkg::CFG_AW-1:0] paddr,
  input  logic [sbpf_pkg::CFG_DW-1:0] pwdata,
  output logic [sbpf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  sbpf_pkg::in_word_t          in_word_r;
  logic                        in_vld_r;
  sbpf_pkg::out_word_t         out_word_r;
  logic                        out_vld_r;

  logic                        advance;
  logic                        proc_en;
  logic                        in_take;
  logic                        res_valid;
  sbpf_pkg::out_word_t         res_word;
  sbpf_pkg::bar_wr_t           bar_wr;
  sbpf_pkg::bar_rd_t           bar_rd;
  logic [sbpf_pkg::BAR_W-1:0]  bar_cur;
  logic [sbpf_pkg::BAR_W-1:0]  falloff_step;

  assign advance  = !out_vld_r || !out_stall;
  assign proc_en  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (proc_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  sbpf_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .falloff_step (falloff_step)
  );

  sbpf_bar_mem u_bar_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (bar_wr),
    .rd     (bar_rd),
    .rd_bar (bar_cur)
  );

  sbpf_band_proc u_band_proc (
    .clk          (clk),
    .rst_n        (rst_n),
    .proc_en      (proc_en),
    .in_word      (in_word_r),
    .falloff_step (falloff_step),
    .bar_cur      (bar_cur),
    .res_valid    (res_valid),
    .res_word     (res_word),
    .bar_wr       (bar_wr),
    .bar_rd       (bar_rd)
  );

endmodule
